FILE: hdl/rx_ring_buffer_int_parser_core_macros.svh
// Assertion macros for the port-level checker file.
`ifndef RX_RING_BUFFER_INT_PARSER_CORE_MACROS_SVH
`define RX_RING_BUFFER_INT_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRBIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrbip assertion failed");

// Next-cycle implication, disabled during reset.
`define RRBIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrbip assertion failed");

`endif

FILE: hdl/rrbip_pkg.sv
// Types and constants of the receive ring buffer with integer parser.
`default_nettype none

package rrbip_pkg;

    localparam int unsigned BUFFER_DEPTH_DEF = 64;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned LIMIT_W   = 16;

    localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 16'd10000;

    localparam logic [BYTE_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_PARSE = 2'd3
    } t_req;

    // Buffer stage to parser stage.
    typedef struct packed {
        t_req req;
        logic popped;
        logic nonempty;
    } t_stage;

    typedef struct packed {
        logic [BYTE_W-1:0]         read_byte;
        logic                      read_valid;
        logic                      buffer_nonempty;
        logic signed [VALUE_W-1:0] number_value;
        logic                      number_done;
        logic                      timed_out;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/rrbip_buffer.sv
// Ring buffer pointers and byte store; registers the byte at the read pointer for the parser.
`default_nettype none

module rrbip_buffer #(
    parameter int unsigned BUFFER_DEPTH = rrbip_pkg::BUFFER_DEPTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_accept,
    input  wire  [1:0]                        i_req_type,
    input  wire  [rrbip_pkg::BYTE_W-1:0]      i_rx_byte,
    output rrbip_pkg::t_stage                 o_stage,
    output logic [rrbip_pkg::BYTE_W-1:0]      o_rd_data
);

    localparam int unsigned PTR_W = $clog2(BUFFER_DEPTH);

    logic [rrbip_pkg::BYTE_W-1:0] r_mem [BUFFER_DEPTH];
    logic [PTR_W-1:0]             r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]             r_rd_ptr, n_rd_ptr;
    rrbip_pkg::t_stage            r_stage, n_stage;
    logic [rrbip_pkg::BYTE_W-1:0] r_rd_data;
    rrbip_pkg::t_req              req;
    logic                         empty;
    logic [PTR_W-1:0]             wr_inc, rd_inc;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign req    = rrbip_pkg::t_req'(i_req_type);
    assign empty  = (r_wr_ptr == r_rd_ptr);
    assign wr_inc = next_ptr(r_wr_ptr);
    assign rd_inc = next_ptr(r_rd_ptr);

    always_comb begin
        n_wr_ptr       = r_wr_ptr;
        n_rd_ptr       = r_rd_ptr;
        n_stage.req    = req;
        n_stage.popped = 1'b0;
        unique case (req)
            rrbip_pkg::REQ_PUSH: begin
                n_wr_ptr = wr_inc;
                if (wr_inc == r_rd_ptr) begin
                    n_rd_ptr = rd_inc;
                end
            end
            rrbip_pkg::REQ_READ, rrbip_pkg::REQ_PARSE: begin
                if (!empty) begin
                    n_rd_ptr       = rd_inc;
                    n_stage.popped = 1'b1;
                end
            end
            rrbip_pkg::REQ_FLUSH: begin
                n_wr_ptr = r_rd_ptr;
            end
            default: begin
                n_wr_ptr = r_wr_ptr;
            end
        endcase
        n_stage.nonempty = (n_wr_ptr != n_rd_ptr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else if (i_accept) begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_stage   <= n_stage;
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && req == rrbip_pkg::REQ_PUSH) begin
            r_mem[r_wr_ptr] <= i_rx_byte;
        end
    end

    assign o_stage   = r_stage;
    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hdl/rrbip_parser.sv
// Decimal parser state, timeout register and result register.
`default_nettype none

module rrbip_parser (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_adv,
    input  rrbip_pkg::t_stage                 i_stage,
    input  wire  [rrbip_pkg::BYTE_W-1:0]      i_rd_data,
    input  wire                               i_cfg_wr_en,
    input  wire  [rrbip_pkg::LIMIT_W-1:0]     i_cfg_wr_data,
    output rrbip_pkg::t_result                o_result
);

    logic [rrbip_pkg::VALUE_W-1:0] r_acc, n_acc;
    logic                          r_neg, n_neg;
    logic [rrbip_pkg::LIMIT_W-1:0] r_wait, n_wait;
    logic [rrbip_pkg::LIMIT_W-1:0] r_limit;
    rrbip_pkg::t_result            r_res, n_res;
    logic [rrbip_pkg::LIMIT_W-1:0] wait_inc;
    logic [rrbip_pkg::VALUE_W-1:0] acc_mac;

    assign wait_inc = r_wait + 1'b1;
    // acc * 10 + byte - '0', mod 2^64
    assign acc_mac  = (r_acc << 3) + (r_acc << 1)
                    + {{(rrbip_pkg::VALUE_W - rrbip_pkg::BYTE_W){1'b0}}, i_rd_data}
                    - {{(rrbip_pkg::VALUE_W - rrbip_pkg::BYTE_W){1'b0}}, rrbip_pkg::CHAR_ZERO};

    always_comb begin
        n_acc                 = r_acc;
        n_neg                 = r_neg;
        n_wait                = r_wait;
        n_res.read_byte       = '0;
        n_res.read_valid      = 1'b0;
        n_res.buffer_nonempty = i_stage.nonempty;
        n_res.number_value    = '0;
        n_res.number_done     = 1'b0;
        n_res.timed_out       = 1'b0;
        if (i_stage.req == rrbip_pkg::REQ_READ && i_stage.popped) begin
            n_res.read_byte  = i_rd_data;
            n_res.read_valid = 1'b1;
        end
        if (i_stage.req == rrbip_pkg::REQ_PARSE) begin
            if (!i_stage.popped) begin
                if (wait_inc >= r_limit) begin
                    n_res.timed_out = 1'b1;
                    n_acc           = '0;
                    n_neg           = 1'b0;
                    n_wait          = '0;
                end else begin
                    n_wait = wait_inc;
                end
            end else if (i_rd_data == rrbip_pkg::CHAR_MINUS) begin
                n_neg = 1'b1;
            end else if (i_rd_data == rrbip_pkg::CHAR_DOLLAR) begin
                n_res.number_value = r_neg ? -$signed(r_acc) : $signed(r_acc);
                n_res.number_done  = 1'b1;
                n_acc              = '0;
                n_neg              = 1'b0;
                n_wait             = '0;
            end else begin
                n_acc = acc_mac;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_neg  <= 1'b0;
            r_wait <= '0;
        end else if (i_adv) begin
            r_acc  <= n_acc;
            r_neg  <= n_neg;
            r_wait <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= rrbip_pkg::TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

FILE: hdl/rx_ring_buffer_int_parser_core.sv
// Top level: receive ring buffer feeding a decimal integer parser.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall   i_req_type, i_rx_byte
//   out      source     o_out_valid / i_out_stall o_read_byte .. o_timed_out
//   cfg      sink       i_cfg_wr_en               i_cfg_wr_data (timeout_limit)
//
// One beat per cycle sustained while the output is not stalled.
// The buffer stage updates the pointers, writes the store and reads the byte at the
// read pointer into a register; the parser stage runs the parser and loads the result.
// Synchronous active-low reset clears pointers, parser state and valids;
// the byte store is not cleared. A stalled result holds the parser stage,
// which in turn stalls the input.
`default_nettype none

module rx_ring_buffer_int_parser_core #(
    parameter int unsigned BUFFER_DEPTH = rrbip_pkg::BUFFER_DEPTH_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_in_valid,
    output logic                                    o_in_stall,
    input  wire  [1:0]                              i_req_type,
    input  wire  [rrbip_pkg::BYTE_W-1:0]            i_rx_byte,
    input  wire                                     i_cfg_wr_en,
    input  wire  [rrbip_pkg::LIMIT_W-1:0]           i_cfg_wr_data,
    output logic                                    o_out_valid,
    input  wire                                     i_out_stall,
    output logic [rrbip_pkg::BYTE_W-1:0]            o_read_byte,
    output logic                                    o_read_valid,
    output logic                                    o_buffer_nonempty,
    output logic signed [rrbip_pkg::VALUE_W-1:0]    o_number_value,
    output logic                                    o_number_done,
    output logic                                    o_timed_out
);

    logic                         r_s1_vld, n_s1_vld;
    logic                         r_out_vld, n_out_vld;
    logic                         accept;
    logic                         s1_adv;
    rrbip_pkg::t_stage            stage;
    logic [rrbip_pkg::BYTE_W-1:0] rd_data;
    rrbip_pkg::t_result           result;

    assign s1_adv     = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_vld  = accept ? 1'b1 : (s1_adv ? 1'b0 : r_s1_vld);
        n_out_vld = s1_adv ? 1'b1 : (i_out_stall ? r_out_vld : 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    rrbip_buffer #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_buffer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .o_stage    (stage),
        .o_rd_data  (rd_data)
    );

    rrbip_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (s1_adv),
        .i_stage       (stage),
        .i_rd_data     (rd_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (result)
    );

    assign o_out_valid       = r_out_vld;
    assign o_read_byte       = result.read_byte;
    assign o_read_valid      = result.read_valid;
    assign o_buffer_nonempty = result.buffer_nonempty;
    assign o_number_value    = result.number_value;
    assign o_number_done     = result.number_done;
    assign o_timed_out       = result.timed_out;

endmodule

`default_nettype wire

FILE: hdl/rrbip_checker.sv
// Port-level checker for the ring buffer parser core, bound to the top level.
`default_nettype none

`include "rx_ring_buffer_int_parser_core_macros.svh"

module rrbip_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  o_out_valid,
    input wire                                  i_out_stall,
    input wire [rrbip_pkg::BYTE_W-1:0]          o_read_byte,
    input wire                                  o_read_valid,
    input wire signed [rrbip_pkg::VALUE_W-1:0]  o_number_value,
    input wire                                  o_number_done,
    input wire                                  o_timed_out
);

    // at most one of read hit, number done, timeout per beat
    `RRBIP_ASSERT_NOW(a_one_event, i_clk, i_rst_n, o_out_valid, $onehot0({o_read_valid, o_number_done, o_timed_out}))
    `RRBIP_ASSERT_NOW(a_byte_zero, i_clk, i_rst_n, o_out_valid && !o_read_valid, o_read_byte == '0)
    `RRBIP_ASSERT_NOW(a_value_zero, i_clk, i_rst_n, o_out_valid && !o_number_done, o_number_value == '0)
    `RRBIP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

endmodule

bind rx_ring_buffer_int_parser_core rrbip_checker u_rrbip_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_read_byte    (o_read_byte),
    .o_read_valid   (o_read_valid),
    .o_number_value (o_number_value),
    .o_number_done  (o_number_done),
    .o_timed_out    (o_timed_out)
);

`default_nettype wire

FILE: verif/tb_rx_ring_buffer_int_parser_core.sv
// Testbench for the receive ring buffer with decimal integer parser.
`timescale 1ns / 100ps

module tb_rx_ring_buffer_int_parser_core;
    import rrbip_pkg::*;

    localparam int unsigned DEPTH = BUFFER_DEPTH_DEF;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_req in_req = REQ_PUSH;
    logic [BYTE_W-1:0] in_byte = '0;
    logic cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;
    logic out_stall = 1'b0;

    logic o_in_stall;
    logic o_out_valid;
    logic [BYTE_W-1:0] o_read_byte;
    logic o_read_valid;
    logic o_buffer_nonempty;
    logic signed [VALUE_W-1:0] o_number_value;
    logic o_number_done;
    logic o_timed_out;

    // predictor state
    logic [BYTE_W-1:0] byte_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr = '0;
    logic [PTR_W-1:0] rd_ptr = '0;
    logic [VALUE_W-1:0] acc = '0;
    logic neg_flag = 1'b0;
    logic [LIMIT_W-1:0] wait_cnt = '0;
    logic [LIMIT_W-1:0] limit_reg = TIMEOUT_RESET;

    t_result pending_results[$];
    t_result want_r;
    bit in_gaps = 1'b1;
    bit out_gaps = 1'b1;
    int stall_left = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int n_beats = 0;
    int n_numbers = 0;
    int n_timeouts = 0;
    int n_reads = 0;

    rx_ring_buffer_int_parser_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (in_req),
        .i_rx_byte         (in_byte),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_wr_data     (cfg_wr_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_read_byte       (o_read_byte),
        .o_read_valid      (o_read_valid),
        .o_buffer_nonempty (o_buffer_nonempty),
        .o_number_value    (o_number_value),
        .o_number_done     (o_number_done),
        .o_timed_out       (o_timed_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void clear_number();
        acc = '0;
        neg_flag = 1'b0;
        wait_cnt = '0;
    endfunction

    function automatic t_result step_buffer_parser(t_req req, logic [BYTE_W-1:0] b);
        t_result r;
        logic [BYTE_W-1:0] c;
        r = '0;
        case (req)
            REQ_PUSH: begin
                byte_mem[wr_ptr] = b;
                wr_ptr = wr_ptr + 1'b1;
                if (wr_ptr == rd_ptr)
                    rd_ptr = rd_ptr + 1'b1;
            end
            REQ_READ: begin
                if (wr_ptr != rd_ptr) begin
                    r.read_byte = byte_mem[rd_ptr];
                    r.read_valid = 1'b1;
                    rd_ptr = rd_ptr + 1'b1;
                    n_reads++;
                end
            end
            REQ_FLUSH: wr_ptr = rd_ptr;
            REQ_PARSE: begin
                if (wr_ptr == rd_ptr) begin
                    wait_cnt = wait_cnt + 1'b1;
                    if (wait_cnt >= limit_reg) begin
                        r.timed_out = 1'b1;
                        clear_number();
                        n_timeouts++;
                    end
                end else begin
                    c = byte_mem[rd_ptr];
                    rd_ptr = rd_ptr + 1'b1;
                    if (c == CHAR_MINUS) begin
                        neg_flag = 1'b1;
                    end else if (c == CHAR_DOLLAR) begin
                        r.number_value = neg_flag ? -acc : acc;
                        r.number_done = 1'b1;
                        clear_number();
                        n_numbers++;
                    end else begin
                        acc = acc * 64'd10 + 64'(c) - 64'(CHAR_ZERO);
                    end
                end
            end
        endcase
        r.buffer_nonempty = (wr_ptr != rd_ptr);
        return r;
    endfunction

    // Leaves valid high on return so back-to-back beats need no second assignment.
    task automatic send_beat(input t_req req, input logic [BYTE_W-1:0] b);
        if (in_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req <= req;
        in_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(step_buffer_parser(req, b));
        n_beats++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        limit_reg = v;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with nothing expected, expected none actual %0h",
                         $time, o_number_value);
            end else begin
                want_r = pending_results.pop_front();
                check_field("read_byte", want_r.read_byte, o_read_byte);
                check_field("read_valid", want_r.read_valid, o_read_valid);
                check_field("buffer_nonempty", want_r.buffer_nonempty, o_buffer_nonempty);
                check_field("number_value", want_r.number_value, o_number_value);
                check_field("number_done", want_r.number_done, o_number_done);
                check_field("timed_out", want_r.timed_out, o_timed_out);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!out_gaps) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end else begin
            out_stall <= 1'b0;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic test_push_read();
        write_limit(TIMEOUT_RESET);
        send_beat(REQ_PUSH, 8'h00);
        send_beat(REQ_PUSH, 8'hFF);
        send_beat(REQ_READ, 8'hFF);
        send_beat(REQ_READ, 8'h00);
        send_beat(REQ_READ, 8'hA5);
        send_beat(REQ_PUSH, 8'h5A);
        send_beat(REQ_FLUSH, 8'h00);
        send_beat(REQ_READ, 8'h00);
        drain();
    endtask

    // flush drops buffered bytes but not the partial number
    task automatic test_flush_keeps_number();
        send_beat(REQ_PUSH, CHAR_MINUS);
        send_beat(REQ_PUSH, CHAR_ZERO + 8'd4);
        send_beat(REQ_PARSE, 8'h00);
        send_beat(REQ_PARSE, 8'h00);
        send_beat(REQ_PUSH, CHAR_ZERO + 8'd9);
        send_beat(REQ_FLUSH, 8'h00);
        send_beat(REQ_PUSH, CHAR_DOLLAR);
        send_beat(REQ_PARSE, 8'h00);
        drain();
    endtask

    // wait count survives popped bytes; a non-digit byte still accumulates
    task automatic test_parse_timeout();
        write_limit(16'd3);
        send_beat(REQ_PARSE, 8'h00);
        send_beat(REQ_PUSH, CHAR_ZERO + 8'd5);
        send_beat(REQ_PARSE, 8'h00);
        send_beat(REQ_PARSE, 8'h00);
        send_beat(REQ_PARSE, 8'h00);
        drain();
        write_limit(16'd1);
        send_beat(REQ_PARSE, 8'h00);
        send_beat(REQ_PUSH, 8'h41);
        send_beat(REQ_PUSH, CHAR_DOLLAR);
        send_beat(REQ_PARSE, 8'h00);
        send_beat(REQ_PARSE, 8'h00);
        drain();
    endtask

    task automatic test_overflow();
        send_beat(REQ_FLUSH, 8'($urandom));
        repeat (DEPTH + 6) send_beat(REQ_PUSH, 8'($urandom));
        repeat (DEPTH + 2) send_beat(REQ_READ, 8'($urandom));
        drain();
    endtask

    task automatic test_random_traffic(input int n, input logic [LIMIT_W-1:0] lim);
        int start;
        int kind;
        int len;
        int pending;
        logic [BYTE_W-1:0] seq[$];
        write_limit(lim);
        start = n_beats;
        while (n_beats - start < n) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                // kinds 5 and 6 build broken numbers: no terminator or a junk byte
                seq.delete();
                if ($urandom_range(0, 2) == 0)
                    seq.push_back(CHAR_MINUS);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 22)
                                                  : $urandom_range(1, 6);
                repeat (len) seq.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                if (kind == 6)
                    seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom);
                if (kind != 5)
                    seq.push_back(CHAR_DOLLAR);
                pending = 0;
                foreach (seq[i]) begin
                    send_beat(REQ_PUSH, seq[i]);
                    pending++;
                    if ($urandom_range(0, 3) == 0) begin
                        send_beat(REQ_PARSE, 8'($urandom));
                        pending--;
                    end
                end
                repeat (pending) send_beat(REQ_PARSE, 8'($urandom));
            end else if (kind == 7) begin
                send_beat(t_req'($urandom_range(0, 3)), 8'($urandom));
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 4)) send_beat(REQ_READ, 8'($urandom));
            end else begin
                len = (limit_reg > 12) ? $urandom_range(1, 4)
                                       : $urandom_range(1, limit_reg + 1);
                repeat (len) send_beat(REQ_PARSE, 8'($urandom));
            end
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_push_read();
        test_flush_keeps_number();
        test_parse_timeout();
        test_overflow();
        test_random_traffic(100, 16'hFFFF);
        test_random_traffic(70, 16'($urandom_range(1, 12)));
        in_gaps = 1'b0;
        out_gaps = 1'b0;
        test_random_traffic(50, TIMEOUT_RESET);
        $display("Ran %0d beats over push, read, flush and parse with wraparound and overflow,",
                 n_beats);
        $display("%0d numbers parsed, %0d timeouts, %0d reads with data, %0d mismatches.",
                 n_numbers, n_timeouts, n_reads, mismatch_count);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/rrbip_pkg.sv
hdl/rrbip_buffer.sv
hdl/rrbip_parser.sv
hdl/rx_ring_buffer_int_parser_core.sv
hdl/rrbip_checker.sv
verif/tb_rx_ring_buffer_int_parser_core.sv
